### rtl/sgcp_pkg.sv
`timescale 1ns / 1ps

package sgcp_pkg;

    // Default list depth and the cap on chunks per start
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int RESULT_LIMIT    = 32;
    localparam int KCNT_W          = $clog2(RESULT_LIMIT + 1);

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 16;
    localparam int BYTES_W = 24;
    localparam int CFG_W   = 24;

    // Command codes
    typedef enum logic [1:0] {
        CMD_LOAD_SRC = 2'd0,
        CMD_LOAD_DST = 2'd1,
        CMD_START    = 2'd2
    } t_cmd;

    // Configuration register indexes
    localparam logic CFG_SRC_OFFSET = 1'b0;
    localparam logic CFG_BYTE_COUNT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_LOOP,
        ST_SRC_LOAD,
        ST_DST_LOAD,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] segment_address;
        logic [LEN_W-1:0]  segment_length;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0]  chunk_source_address;
        logic [ADDR_W-1:0]  chunk_dest_address;
        logic [LEN_W-1:0]   chunk_length;
        logic [BYTES_W-1:0] total_copied;
        logic               last_chunk;
    } t_out;

    // One list entry as stored
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } t_seg;

endpackage

### rtl/scatter_gather_copy_planner.sv
`timescale 1ns / 1ps

// Scatter-gather copy planner. Command words load one source or destination
// list entry each (loads into a full list are dropped) or start planning. A
// start walks both lists with one small sequencer: it skips the source
// entries that lie wholly before source_offset, begins the walk, produces
// the chunks, and passes through a load state each time a list moves to its
// next entry, since the list memories return registered read data, then
// sends the final word. Chunk words leave through an output register with
// one word held back so the final one can carry last_chunk; output stalls
// hold the walk. The input is stalled from the start word until its last
// result is loaded into the output register, and a start empties both lists.
module scatter_gather_copy_planner #(
    parameter int MAX_ENTRIES = sgcp_pkg::DEF_MAX_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  sgcp_pkg::t_in              i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output sgcp_pkg::t_out             o_data,
    input  logic                       i_stall,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [sgcp_pkg::CFG_W-1:0] i_cfg_data
);
    import sgcp_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // List memories and their registered read data
    t_seg r_src_mem [MAX_ENTRIES];
    t_seg r_dst_mem [MAX_ENTRIES];
    t_seg r_src_rd, r_dst_rd;

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_scnt, n_scnt, r_dcnt, n_dcnt;
    logic [CNT_W-1:0]   r_si, n_si, r_di, n_di;
    logic [BYTES_W-1:0] r_off, n_off;
    logic [LEN_W-1:0]   r_src_pos, n_src_pos, r_src_left, n_src_left;
    logic [LEN_W-1:0]   r_dst_pos, n_dst_pos, r_dst_left, n_dst_left;
    logic [BYTES_W-1:0] r_total, n_total;
    logic [KCNT_W-1:0]  r_k, n_k;
    logic [BYTES_W-1:0] r_src_offset, r_byte_count;
    t_out               r_out, n_out, r_pend, n_pend;
    logic               r_out_vld, n_out_vld, r_pend_vld, n_pend_vld;

    logic               w_accept, w_out_free, w_src_we, w_dst_we;
    logic [BYTES_W-1:0] w_remain;
    logic [LEN_W-1:0]   w_min_sd, w_n;
    logic [CNT_W-1:0]   w_si_inc, w_di_inc;

    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_vld || !i_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_out_vld;
    assign o_data     = r_out;

    assign w_src_we = w_accept && (i_data.command == CMD_LOAD_SRC)
                      && (r_scnt < CNT_W'(MAX_ENTRIES));
    assign w_dst_we = w_accept && (i_data.command == CMD_LOAD_DST)
                      && (r_dcnt < CNT_W'(MAX_ENTRIES));

    // Chunk length: smaller of both segment remainders and the bytes still owed
    assign w_remain = r_byte_count - r_total;
    assign w_min_sd = (r_src_left < r_dst_left) ? r_src_left : r_dst_left;
    assign w_n      = ({{(BYTES_W-LEN_W){1'b0}}, w_min_sd} > w_remain)
                      ? w_remain[LEN_W-1:0] : w_min_sd;
    assign w_si_inc = r_si + CNT_W'(1);
    assign w_di_inc = r_di + CNT_W'(1);

    // Write on load, read at the next entry index
    always_ff @(posedge i_clk) begin
        if (w_src_we) begin
            r_src_mem[r_scnt[IDX_W-1:0]] <= t_seg'({i_data.segment_address,
                                                    i_data.segment_length});
        end
        if (w_dst_we) begin
            r_dst_mem[r_dcnt[IDX_W-1:0]] <= t_seg'({i_data.segment_address,
                                                    i_data.segment_length});
        end
        r_src_rd <= r_src_mem[n_si[IDX_W-1:0]];
        r_dst_rd <= r_dst_mem[n_di[IDX_W-1:0]];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_offset <= '0;
            r_byte_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_OFFSET: r_src_offset <= i_cfg_data;
                CFG_BYTE_COUNT: r_byte_count <= i_cfg_data;
                default:        r_byte_count <= r_byte_count;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scnt     <= '0;
            r_dcnt     <= '0;
            r_si       <= '0;
            r_di       <= '0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scnt     <= n_scnt;
            r_dcnt     <= n_dcnt;
            r_si       <= n_si;
            r_di       <= n_di;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    // Walk registers and result words
    always_ff @(posedge i_clk) begin
        r_off      <= n_off;
        r_src_pos  <= n_src_pos;
        r_src_left <= n_src_left;
        r_dst_pos  <= n_dst_pos;
        r_dst_left <= n_dst_left;
        r_total    <= n_total;
        r_k        <= n_k;
        r_out      <= n_out;
        r_pend     <= n_pend;
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_scnt     = r_scnt;
        n_dcnt     = r_dcnt;
        n_si       = r_si;
        n_di       = r_di;
        n_off      = r_off;
        n_src_pos  = r_src_pos;
        n_src_left = r_src_left;
        n_dst_pos  = r_dst_pos;
        n_dst_left = r_dst_left;
        n_total    = r_total;
        n_k        = r_k;
        n_out      = r_out;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld && i_stall;
        n_pend_vld = r_pend_vld;

        case (r_state)
            ST_IDLE: begin
                if (w_src_we) n_scnt = r_scnt + CNT_W'(1);
                if (w_dst_we) n_dcnt = r_dcnt + CNT_W'(1);
                if (w_accept && (i_data.command == CMD_START)) begin
                    n_si    = '0;
                    n_di    = '0;
                    n_off   = r_src_offset;
                    n_total = '0;
                    n_k     = '0;
                    n_state = ST_SKIP;
                end
            end

            // Drop whole source entries that lie before the offset
            ST_SKIP: begin
                if ((r_si < r_scnt) &&
                    (r_off >= {{(BYTES_W-LEN_W){1'b0}}, r_src_rd.len})) begin
                    n_off = r_off - {{(BYTES_W-LEN_W){1'b0}}, r_src_rd.len};
                    n_si  = w_si_inc;
                end else if ((r_si < r_scnt) && (r_dcnt != '0)) begin
                    n_src_pos  = r_off[LEN_W-1:0];
                    n_src_left = r_src_rd.len - r_off[LEN_W-1:0];
                    n_dst_pos  = '0;
                    n_dst_left = r_dst_rd.len;
                    n_state    = ST_LOOP;
                end else begin
                    n_state = ST_FLUSH;
                end
            end

            ST_LOOP: begin
                if ((r_total >= r_byte_count) || (r_k == KCNT_W'(RESULT_LIMIT))) begin
                    n_state = ST_FLUSH;
                end else if (r_src_left == '0) begin
                    n_si    = w_si_inc;
                    n_state = (w_si_inc >= r_scnt) ? ST_FLUSH : ST_SRC_LOAD;
                end else if (r_dst_left == '0) begin
                    n_di    = w_di_inc;
                    n_state = (w_di_inc >= r_dcnt) ? ST_FLUSH : ST_DST_LOAD;
                end else if (!r_pend_vld || w_out_free) begin
                    // Push the held word out, hold the new chunk back
                    if (r_pend_vld) begin
                        n_out     = r_pend;
                        n_out_vld = 1'b1;
                    end
                    n_pend.chunk_source_address = r_src_rd.addr
                                                  + {{(ADDR_W-LEN_W){1'b0}}, r_src_pos};
                    n_pend.chunk_dest_address   = r_dst_rd.addr
                                                  + {{(ADDR_W-LEN_W){1'b0}}, r_dst_pos};
                    n_pend.chunk_length         = w_n;
                    n_pend.total_copied         = r_total
                                                  + {{(BYTES_W-LEN_W){1'b0}}, w_n};
                    n_pend.last_chunk           = 1'b0;
                    n_pend_vld = 1'b1;
                    n_total    = r_total + {{(BYTES_W-LEN_W){1'b0}}, w_n};
                    n_k        = r_k + KCNT_W'(1);
                    n_src_pos  = r_src_pos + w_n;
                    n_src_left = r_src_left - w_n;
                    n_dst_pos  = r_dst_pos + w_n;
                    n_dst_left = r_dst_left - w_n;
                end
            end

            ST_SRC_LOAD: begin
                n_src_pos  = '0;
                n_src_left = r_src_rd.len;
                n_state    = ST_LOOP;
            end

            ST_DST_LOAD: begin
                n_dst_pos  = '0;
                n_dst_left = r_dst_rd.len;
                n_state    = ST_LOOP;
            end

            // Send the final word marked last, or an empty word, and clear lists
            ST_FLUSH: begin
                if (w_out_free) begin
                    if (r_pend_vld) begin
                        n_out = r_pend;
                    end else begin
                        n_out = '0;
                    end
                    n_out.last_chunk = 1'b1;
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_scnt     = '0;
                    n_dcnt     = '0;
                    n_si       = '0;
                    n_di       = '0;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import sgcp_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         WORD_TARGET  = 330;
    localparam int         SETTLE_TICKS = 12;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         PRINT_CAP    = 25;

    // Expected chunk store and predictor of the planning walk
    class copy_plan_board;
        t_seg             src_list[DEF_MAX_ENTRIES];
        t_seg             dst_list[DEF_MAX_ENTRIES];
        int unsigned      src_count;
        int unsigned      dst_count;
        logic [CFG_W-1:0] start_offset;
        logic [CFG_W-1:0] copy_bytes;
        t_out             expected_chunks[$];
        int unsigned      mismatches;
        int unsigned      chunks_seen;
        int unsigned      starts_seen;
        int unsigned      settings_used;

        function new();
            src_count     = 0;
            dst_count     = 0;
            start_offset  = '0;
            copy_bytes    = '0;
            mismatches    = 0;
            chunks_seen   = 0;
            starts_seen   = 0;
            settings_used = 0;
        endfunction

        function void set_regs(logic [CFG_W-1:0] offset, logic [CFG_W-1:0] count);
            start_offset = offset;
            copy_bytes   = count;
            settings_used++;
        endfunction

        // Walk both lists and queue the chunks one start produces
        function void plan_copy();
            int unsigned si, di, skip, src_pos, src_left, dst_pos, dst_left;
            int unsigned total, n, emitted;
            bit          done, have_prev;
            t_out        prev, cur;
            si        = 0;
            di        = 0;
            skip      = start_offset;
            total     = 0;
            emitted   = 0;
            done      = 1'b0;
            have_prev = 1'b0;
            prev      = '0;
            cur       = '0;
            // pass over whole source entries that lie before the offset
            while (si < src_count && skip >= src_list[si].len) begin
                skip -= src_list[si].len;
                si++;
            end
            if (si < src_count && dst_count > 0) begin
                src_pos  = skip;
                src_left = src_list[si].len - skip;
                dst_pos  = 0;
                dst_left = dst_list[0].len;
                while (!done && total < copy_bytes && emitted < RESULT_LIMIT) begin
                    if (src_left == 0) begin
                        si++;
                        if (si >= src_count) begin
                            done = 1'b1;
                        end else begin
                            src_pos  = 0;
                            src_left = src_list[si].len;
                        end
                    end else if (dst_left == 0) begin
                        di++;
                        if (di >= dst_count) begin
                            done = 1'b1;
                        end else begin
                            dst_pos  = 0;
                            dst_left = dst_list[di].len;
                        end
                    end else begin
                        n = (src_left < dst_left) ? src_left : dst_left;
                        if (n > copy_bytes - total) n = copy_bytes - total;
                        total += n;
                        cur.chunk_source_address = src_list[si].addr + ADDR_W'(src_pos);
                        cur.chunk_dest_address   = dst_list[di].addr + ADDR_W'(dst_pos);
                        cur.chunk_length         = LEN_W'(n);
                        cur.total_copied         = BYTES_W'(total);
                        cur.last_chunk           = 1'b0;
                        if (have_prev) expected_chunks.push_back(prev);
                        prev      = cur;
                        have_prev = 1'b1;
                        emitted++;
                        src_pos  += n;
                        src_left -= n;
                        dst_pos  += n;
                        dst_left -= n;
                    end
                end
            end
            // nothing copied gives a single word that is zero but for last_chunk
            if (!have_prev) prev = '0;
            prev.last_chunk = 1'b1;
            expected_chunks.push_back(prev);
        endfunction

        // Update the lists for one accepted input word
        function void note_word(t_in w);
            case (w.command)
                CMD_LOAD_SRC: begin
                    if (src_count < DEF_MAX_ENTRIES) begin
                        src_list[src_count].addr = w.segment_address;
                        src_list[src_count].len  = w.segment_length;
                        src_count++;
                    end
                end
                CMD_LOAD_DST: begin
                    if (dst_count < DEF_MAX_ENTRIES) begin
                        dst_list[dst_count].addr = w.segment_address;
                        dst_list[dst_count].len  = w.segment_length;
                        dst_count++;
                    end
                end
                CMD_START: begin
                    plan_copy();
                    src_count = 0;
                    dst_count = 0;
                    starts_seen++;
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("chunk %0d %s: got %h, want %h",
                                          chunks_seen, name, got, want));
        endtask

        // Compare one accepted chunk word against the oldest expectation
        task check_chunk(t_out got);
            t_out want;
            chunks_seen++;
            if (expected_chunks.size() == 0) begin
                report_mismatch($sformatf("chunk %0d with nothing expected: %h",
                                          chunks_seen, got));
            end else begin
                want = expected_chunks.pop_front();
                compare_field("source address", got.chunk_source_address,
                              want.chunk_source_address);
                compare_field("dest address", got.chunk_dest_address,
                              want.chunk_dest_address);
                compare_field("length", ADDR_W'(got.chunk_length), ADDR_W'(want.chunk_length));
                compare_field("total", ADDR_W'(got.total_copied), ADDR_W'(want.total_copied));
                compare_field("last", ADDR_W'(got.last_chunk), ADDR_W'(want.last_chunk));
            end
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_word   = '0;
    logic             in_stall;
    logic             out_valid;
    t_out             out_word;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_idx   = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             idle_on   = 1'b0;
    int unsigned      stall_run = 0;
    int unsigned      cycle_count = 0;
    int unsigned      words_counted = 0;
    t_in              pending_words[$];
    copy_plan_board   sb = new();

    scatter_gather_copy_planner DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .i_data     (in_word),
        .o_stall    (in_stall),
        .o_valid    (out_valid),
        .o_data     (out_word),
        .i_stall    (out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the output side in random bursts while idling is on
    always @(posedge clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_run <= $urandom_range(0, 6);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Check every chunk word taken from the block
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_chunk(out_word);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_in make_word(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                                      logic [LEN_W-1:0] len);
        t_in w;
        w.command         = cmd;
        w.segment_address = addr;
        w.segment_length  = len;
        return w;
    endfunction

    function automatic int unsigned pick_entry_count();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return 0;
        if (r <= 2) return $urandom_range(14, 18);
        return $urandom_range(1, 6);
    endfunction

    function automatic logic [LEN_W-1:0] pick_len(int unsigned mode);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        case (mode)
            0:       return LEN_W'($urandom_range(1, 48));
            1:       return LEN_W'($urandom);
            2:       return (r < 4) ? {LEN_W{1'b1}} : LEN_W'($urandom);
            default: return LEN_W'($urandom_range(1, 600));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 5) == 0) return 32'hFFFF_FF00 | ADDR_W'($urandom_range(0, 255));
        return $urandom;
    endfunction

    // Present one word and hold it until the block takes it
    task automatic send_word(input t_in w);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(w);
        words_counted++;
    endtask

    // Write both registers, then send the queued words and wait for the chunks
    task automatic run_phase(input logic [CFG_W-1:0] offset, input logic [CFG_W-1:0] count);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SRC_OFFSET;
        cfg_data <= offset;
        @(posedge clk);
        cfg_idx  <= CFG_BYTE_COUNT;
        cfg_data <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_regs(offset, count);
        foreach (pending_words[k]) send_word(pending_words[k]);
        in_valid <= 1'b0;
        pending_words.delete();
        while (sb.expected_chunks.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Queue one random pair of lists followed by a start
    task automatic queue_job(output int unsigned src_bytes);
        int unsigned n_src, n_dst, mode, i, j;
        t_in         w;
        src_bytes = 0;
        n_src     = pick_entry_count();
        n_dst     = pick_entry_count();
        mode      = $urandom_range(0, 3);
        i         = 0;
        j         = 0;
        while (i < n_src || j < n_dst) begin
            if ($urandom_range(0, 9) == 0)
                pending_words.push_back(make_word(CMD_UNUSED, $urandom, LEN_W'($urandom)));
            if (i < n_src && (j >= n_dst || $urandom_range(0, 1) == 0)) begin
                w = make_word(CMD_LOAD_SRC, pick_addr(), pick_len(mode));
                if (i < DEF_MAX_ENTRIES) src_bytes += w.segment_length;
                i++;
            end else begin
                w = make_word(CMD_LOAD_DST, pick_addr(), pick_len(mode));
                j++;
            end
            pending_words.push_back(w);
        end
        pending_words.push_back(make_word(CMD_START, $urandom, LEN_W'($urandom)));
    endtask

    initial begin
        int unsigned      src_bytes, extra_bytes, jobs;
        logic [CFG_W-1:0] offset, count;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty lists and an unused command
        pending_words.push_back(make_word(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF));
        pending_words.push_back(make_word(CMD_START, 32'h0, 16'h0));
        run_phase('0, '0);

        // Zero-length entries on both lists and source address wrap
        pending_words.push_back(make_word(CMD_LOAD_SRC, 32'h1234_5678, 16'h0000));
        pending_words.push_back(make_word(CMD_LOAD_SRC, 32'hFFFF_FFFF, 16'hFFFF));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'h0000_0000, 16'h0000));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'h8000_0000, 16'h8000));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'h7FFF_FFFF, 16'hFFFF));
        pending_words.push_back(make_word(CMD_START, 32'h0, 16'h0));
        run_phase(24'd1, {CFG_W{1'b1}});

        // Offset exactly at the end of the source list
        pending_words.push_back(make_word(CMD_LOAD_SRC, 32'h0000_1000, 16'h0010));
        pending_words.push_back(make_word(CMD_LOAD_SRC, 32'h0000_2000, 16'h0020));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'h0000_3000, 16'h0040));
        pending_words.push_back(make_word(CMD_START, 32'h0, 16'h0));
        run_phase(24'h30, 24'h100);

        // Offset far past the end
        pending_words.push_back(make_word(CMD_LOAD_SRC, 32'h0000_1000, 16'h0010));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'h0000_3000, 16'h0040));
        pending_words.push_back(make_word(CMD_START, 32'h0, 16'h0));
        run_phase({CFG_W{1'b1}}, {CFG_W{1'b1}});

        // One list empty, lists cleared by start, byte count cutting a chunk
        pending_words.push_back(make_word(CMD_LOAD_SRC, 32'h0000_0100, 16'h0008));
        pending_words.push_back(make_word(CMD_START, 32'h0, 16'h0));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'h0000_0200, 16'h0008));
        pending_words.push_back(make_word(CMD_START, 32'h0, 16'h0));
        pending_words.push_back(make_word(CMD_LOAD_SRC, 32'h0000_0300, 16'h0014));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'h0000_0400, 16'h0003));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'h0000_0500, 16'h0003));
        pending_words.push_back(make_word(CMD_START, 32'h0, 16'h0));
        run_phase('0, 24'd5);

        // Byte count of zero
        pending_words.push_back(make_word(CMD_LOAD_SRC, 32'hDEAD_0000, 16'h0100));
        pending_words.push_back(make_word(CMD_LOAD_DST, 32'hBEEF_0000, 16'h0100));
        pending_words.push_back(make_word(CMD_START, 32'h0, 16'h0));
        run_phase('0, '0);

        // Random list pairs; the last stretch runs with no idling
        while (words_counted < WORD_TARGET) begin
            idle_on <= (words_counted < WORD_TARGET * 4 / 5) && ($urandom_range(0, 3) != 0);
            queue_job(src_bytes);
            jobs = $urandom_range(1, 2);
            if (jobs == 2) queue_job(extra_bytes);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: offset = (src_bytes == 0) ? '0 :
                                        CFG_W'($urandom_range(0, src_bytes - 1));
                5:             offset = '0;
                6:             offset = {CFG_W{1'b1}};
                7:             offset = CFG_W'(src_bytes);
                default:       offset = CFG_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: count = CFG_W'($urandom_range(1, src_bytes + src_bytes / 2 + 1));
                5:             count = {CFG_W{1'b1}};
                6:             count = '0;
                7:             count = CFG_W'($urandom_range(1, 16));
                default:       count = CFG_W'($urandom);
            endcase
            run_phase(offset, count);
        end

        $display("Covered %0d start commands over %0d register settings, %0d words in all",
                 sb.starts_seen, sb.settings_used, words_counted);
        $display("Checked %0d chunk words, %0d mismatches", sb.chunks_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/sgcp_pkg.sv
rtl/scatter_gather_copy_planner.sv
tb/tb_top.sv
